// ===== sv/ssc_pkg.sv =====
// Package for the subarray sum counter: field widths, defaults and the
// control bundle that rides with each item down the match chain.
// No dependencies.
package ssc_pkg;

   localparam int ELEM_W      = 16;   // input element, signed
   localparam int TARGET_W    = 24;   // target register, signed
   localparam int COUNT_W     = 16;   // match count result
   localparam int MAX_LEN_DEF = 256;  // default sequence capacity

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Control bits of an item moving through the chain.
   typedef struct packed {
      logic valid;     // stage holds an item
      logic active;    // element was taken into the store (not dropped)
      logic last;      // final element of its sequence
      logic overflow;  // sequence has dropped an element up to and including this one
   } tok_ctl_type;

endpackage

// ===== sv/ssc_cell.sv =====
// One cell of the match chain: holds one stored prefix sum and one
// pipeline slot of the passing query. Depends on ssc_pkg.
module ssc_cell #(
   parameter int INDEX  = 0,
   parameter int PW     = 24,
   parameter int WANT_W = 25,
   parameter int CNT_W  = 9,
   parameter int HIT_W  = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                wr_en,
   input  logic [CNT_W-1:0]    wr_idx,
   input  logic [PW-1:0]       wr_data,
   input  ssc_pkg::tok_ctl_type in_ctl,
   input  logic [WANT_W-1:0]   in_want,
   input  logic [CNT_W-1:0]    in_limit,
   input  logic [HIT_W-1:0]    in_hits,
   output ssc_pkg::tok_ctl_type out_ctl,
   output logic [WANT_W-1:0]   out_want,
   output logic [CNT_W-1:0]    out_limit,
   output logic [HIT_W-1:0]    out_hits
);
   import ssc_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic [PW-1:0]     prefix_ff;
   tok_ctl_type       ctl_ff;
   logic [WANT_W-1:0] want_ff;
   logic [CNT_W-1:0]  limit_ff;
   logic [HIT_W-1:0]  hits_ff;

   logic [WANT_W-1:0] prefix_ext;
   logic              hit;
   logic [HIT_W-1:0]  hits_in;

   assign prefix_ext = {{(WANT_W-PW){prefix_ff[PW-1]}}, prefix_ff};
   // only prefixes stored before this query belong to its window
   assign hit     = in_ctl.valid && in_ctl.active && (MY_IDX < in_limit)
                    && (prefix_ext == in_want);
   assign hits_in = hit ? in_hits + HIT_W'(1) : in_hits;

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == MY_IDX)) begin
         prefix_ff <= wr_data;
      end
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= in_ctl;
      end
      if (advance) begin
         want_ff  <= in_want;
         limit_ff <= in_limit;
         hits_ff  <= hits_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_want  = want_ff;
   assign out_limit = limit_ff;
   assign out_hits  = hits_ff;

endmodule

// ===== sv/ssc_drain.sv =====
// Tail of the match chain: sums per-item hits with saturation and holds
// the result item until taken. Depends on ssc_pkg.
module ssc_drain #(
   parameter int HIT_W = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   output logic                        advance,
   input  ssc_pkg::tok_ctl_type        in_ctl,
   input  logic [HIT_W-1:0]            in_hits,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ssc_pkg::COUNT_W-1:0] rsp_tdata,  // [15:0] match_count
   output logic                        rsp_tuser   // [0] overflow
);
   import ssc_pkg::*;

   localparam int SUM_W = ((COUNT_W > HIT_W) ? COUNT_W : HIT_W) + 1;

   logic [COUNT_W-1:0] total_ff, total_in;
   logic               valid_ff, valid_in;
   logic [COUNT_W-1:0] data_ff, data_in;
   logic               user_ff, user_in;

   logic [SUM_W-1:0]   sum;
   logic [COUNT_W-1:0] sum_sat;

   assign advance = !valid_ff || rsp_tready;
   assign sum     = SUM_W'(total_ff) + SUM_W'(in_hits);
   assign sum_sat = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];

   always_comb begin
      total_in = total_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      if (advance) begin
         valid_in = 1'b0;
         if (in_ctl.valid) begin
            if (in_ctl.last) begin
               valid_in = 1'b1;
               data_in  = sum_sat;
               user_in  = in_ctl.overflow;
               total_in = '0;
            end else begin
               total_in = sum_sat;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

// ===== sv/subarray_sum_count.sv =====
// Subarray sum counter. Throughput: one item per cycle while rsp side takes results.
// A result is formed as its last item's query walks the entry register, the chain
// of MAX_LEN prefix cells and the drain's result register.
// The whole chain stalls while a finished result waits on rsp_tready.
// Reset: synchronous; clears sequence state, chain valids and target_sum (to 0).
// Depends on ssc_pkg, ssc_cell, ssc_drain.
module subarray_sum_count #(
   parameter int MAX_LEN = ssc_pkg::MAX_LEN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // input items
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ssc_pkg::ELEM_W-1:0]   req_tdata,   // [15:0] element (signed)
   input  logic                         req_tlast,   // last
   // result items
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ssc_pkg::COUNT_W-1:0]  rsp_tdata,   // [15:0] match_count
   output logic                         rsp_tuser,   // [0] overflow
   // target_sum register
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ssc_pkg::TARGET_W-1:0] csr_data     // [23:0] target_sum (signed)
);
   import ssc_pkg::*;

   // Prefix sum width: MAX_LEN elements of ELEM_W bits never overflow it.
   localparam int PW     = ELEM_W + $clog2(MAX_LEN);
   // Search key p - target needs one bit over the wider operand.
   localparam int WANT_W = ((PW > TARGET_W) ? PW : TARGET_W) + 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int HIT_W  = $clog2(MAX_LEN + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_LEN);

   // Sequence state
   logic [TARGET_W-1:0] target_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PW-1:0]       running_ff, running_in;
   logic                ovf_ff, ovf_in;

   logic advance;
   logic accept;
   logic full;

   logic [PW-1:0]     prefix;
   logic [WANT_W-1:0] prefix_ext, target_ext, want;
   logic              self_hit;

   // Chain stage arrays: stage 0 is the entry register, stage i+1 is cell i.
   tok_ctl_type       st_ctl   [0:MAX_LEN];
   logic [WANT_W-1:0] st_want  [0:MAX_LEN];
   logic [CNT_W-1:0]  st_limit [0:MAX_LEN];
   logic [HIT_W-1:0]  st_hits  [0:MAX_LEN];

   tok_ctl_type       ent_ctl_ff, ent_ctl_in;
   logic [WANT_W-1:0] ent_want_ff;
   logic [CNT_W-1:0]  ent_limit_ff;
   logic [HIT_W-1:0]  ent_hits_ff;

   logic wr_en;

   assign csr_ready  = 1'b1;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign full       = (count_ff == FULL_CNT);

   // New prefix and the key that earlier prefixes must equal
   assign prefix     = running_ff + {{(PW-ELEM_W){req_tdata[ELEM_W-1]}}, req_tdata};
   assign prefix_ext = {{(WANT_W-PW){prefix[PW-1]}}, prefix};
   assign target_ext = {{(WANT_W-TARGET_W){target_ff[TARGET_W-1]}}, target_ff};
   assign want       = prefix_ext - target_ext;
   // run starting at the first element
   assign self_hit   = (prefix_ext == target_ext);

   assign wr_en = accept && !full;

   always_comb begin
      count_in   = count_ff;
      running_in = running_ff;
      ovf_in     = ovf_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in   = '0;
            running_in = '0;
            ovf_in     = 1'b0;
         end else if (full) begin
            ovf_in     = 1'b1;
         end else begin
            count_in   = count_ff + CNT_W'(1);
            running_in = prefix;
         end
      end
   end

   always_comb begin
      ent_ctl_in          = '0;
      ent_ctl_in.valid    = accept;
      ent_ctl_in.active   = !full;
      ent_ctl_in.last     = req_tlast;
      ent_ctl_in.overflow = ovf_ff || full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         count_ff   <= '0;
         running_ff <= '0;
         ovf_ff     <= 1'b0;
         ent_ctl_ff <= '0;
      end else begin
         if (csr_valid) begin
            target_ff <= csr_data;
         end
         count_ff   <= count_in;
         running_ff <= running_in;
         ovf_ff     <= ovf_in;
         if (advance) begin
            ent_ctl_ff <= ent_ctl_in;
         end
      end
      if (advance) begin
         ent_want_ff  <= want;
         ent_limit_ff <= count_ff;
         ent_hits_ff  <= (self_hit && !full) ? HIT_W'(1) : '0;
      end
   end

   assign st_ctl[0]   = ent_ctl_ff;
   assign st_want[0]  = ent_want_ff;
   assign st_limit[0] = ent_limit_ff;
   assign st_hits[0]  = ent_hits_ff;

   // Row of prefix cells; the new prefix is written straight into its slot
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      ssc_cell #(
         .INDEX  (i),
         .PW     (PW),
         .WANT_W (WANT_W),
         .CNT_W  (CNT_W),
         .HIT_W  (HIT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .wr_en     (wr_en),
         .wr_idx    (count_ff),
         .wr_data   (prefix),
         .in_ctl    (st_ctl[i]),
         .in_want   (st_want[i]),
         .in_limit  (st_limit[i]),
         .in_hits   (st_hits[i]),
         .out_ctl   (st_ctl[i+1]),
         .out_want  (st_want[i+1]),
         .out_limit (st_limit[i+1]),
         .out_hits  (st_hits[i+1])
      );
   end

   // Accumulate per-item hits and hold the result item
   ssc_drain #(
      .HIT_W (HIT_W)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ctl     (st_ctl[MAX_LEN]),
      .in_hits    (st_hits[MAX_LEN]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
